// ===== hw/rtl/ptsp_pkg.sv =====
// Shared types and constants for the pan/tilt servo pulse generator.
package ptsp_pkg;

	// Fixed field widths of the register file and the response
	localparam int WIDTH_BITS  = 12;
	localparam int STEP_BITS   = 8;
	localparam int PERIOD_BITS = 16;
	localparam int CFG_ADDR_W  = 3;
	localparam int CFG_DATA_W  = 16;

	// Reset value of both channel positions
	localparam int CENTER_RESET = 1500;

	// Command queue between the front and back parts
	localparam int QDEPTH  = 2;
	localparam int QPTR_W  = 1;
	localparam int QCOUNT_W = 2;

	// Input mode codes
	localparam logic [1:0] MODE_TICK   = 2'd0;
	localparam logic [1:0] MODE_CENTER = 2'd1;
	localparam logic [1:0] MODE_STOP   = 2'd2;
	localparam logic [1:0] MODE_MOVE   = 2'd3;

	// Direction codes (anything else is treated as hold)
	localparam logic [1:0] DIR_HOLD = 2'd0;
	localparam logic [1:0] DIR_DEC  = 2'd1;
	localparam logic [1:0] DIR_INC  = 2'd2;

	// Internal operation codes
	localparam logic [1:0] OP_TICK   = 2'd0;
	localparam logic [1:0] OP_CENTER = 2'd1;
	localparam logic [1:0] OP_NONE   = 2'd2;
	localparam logic [1:0] OP_MOVE   = 2'd3;

	// Register indexes
	localparam logic [CFG_ADDR_W-1:0] REG_STEP_SIZE    = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_PAN_MINIMUM  = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_PAN_CENTER   = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_PAN_MAXIMUM  = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_TILT_MINIMUM = 3'd4;
	localparam logic [CFG_ADDR_W-1:0] REG_TILT_CENTER  = 3'd5;
	localparam logic [CFG_ADDR_W-1:0] REG_TILT_MAXIMUM = 3'd6;
	localparam logic [CFG_ADDR_W-1:0] REG_FRAME_PERIOD = 3'd7;

	typedef struct packed {
		logic [1:0] mode;
		logic [1:0] pan_direction;
		logic [1:0] tilt_direction;
	} cmd_t;

	typedef struct packed {
		logic                  pan_level;
		logic                  tilt_level;
		logic                  frame_start;
		logic [WIDTH_BITS-1:0] pan_width;
		logic [WIDTH_BITS-1:0] tilt_width;
	} rsp_t;

	typedef struct packed {
		logic [1:0] op;
		logic [1:0] pan_dir;
		logic [1:0] tilt_dir;
	} op_t;

	typedef struct packed {
		logic [STEP_BITS-1:0]   step_size;
		logic [WIDTH_BITS-1:0]  pan_minimum;
		logic [WIDTH_BITS-1:0]  pan_center;
		logic [WIDTH_BITS-1:0]  pan_maximum;
		logic [WIDTH_BITS-1:0]  tilt_minimum;
		logic [WIDTH_BITS-1:0]  tilt_center;
		logic [WIDTH_BITS-1:0]  tilt_maximum;
		logic [PERIOD_BITS-1:0] frame_period;
	} cfg_t;

endpackage

// ===== hw/rtl/ptsp_front.sv =====
// Front part: takes command transactions and registers them as decoded operations.
module ptsp_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	output logic            cmd_ready,
	input  ptsp_pkg::cmd_t  cmd,
	output logic            op_valid,
	input  logic            op_ready,
	output ptsp_pkg::op_t   op
);
	import ptsp_pkg::*;

	op_t  op_s1;
	logic valid_s1;
	op_t  dec;

	// Normalize directions so the back part only sees hold/dec/inc
	function automatic logic [1:0] norm_dir(input logic [1:0] d);
		if (d == DIR_DEC || d == DIR_INC) begin
			return d;
		end
		return DIR_HOLD;
	endfunction

	always_comb begin
		dec.pan_dir  = DIR_HOLD;
		dec.tilt_dir = DIR_HOLD;
		case (cmd.mode)
			MODE_TICK: begin
				dec.op = OP_TICK;
			end
			MODE_CENTER: begin
				dec.op = OP_CENTER;
			end
			MODE_MOVE: begin
				dec.op       = OP_MOVE;
				dec.pan_dir  = norm_dir(cmd.pan_direction);
				dec.tilt_dir = norm_dir(cmd.tilt_direction);
			end
			default: begin
				dec.op = OP_NONE;
			end
		endcase
	end

	assign cmd_ready = !valid_s1 || op_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_ready) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			op_s1 <= dec;
		end
	end

	assign op_valid = valid_s1;
	assign op       = op_s1;

endmodule

// ===== hw/rtl/ptsp_queue.sv =====
// Two-entry operation queue between the front and back parts.
module ptsp_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  ptsp_pkg::op_t  push_op,
	output logic           pop_valid,
	input  logic           pop,
	output ptsp_pkg::op_t  pop_op
);
	import ptsp_pkg::*;

	op_t                 entries_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCOUNT_W-1:0] count_q;
	logic                do_push;
	logic                do_pop;

	assign push_ready = (count_q != QCOUNT_W'(QDEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_op     = entries_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_op;
		end
	end

endmodule

// ===== hw/rtl/ptsp_back.sv =====
// Back part: servo position, frame counter and pulse levels, with the response register.
module ptsp_back #(
	parameter int PULSE_BITS = 12,
	parameter int FRAME_BITS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  ptsp_pkg::cfg_t cfg,
	input  logic           op_valid,
	output logic           op_pop,
	input  ptsp_pkg::op_t  op,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output ptsp_pkg::rsp_t rsp
);
	import ptsp_pkg::*;

	localparam int WW   = (PULSE_BITS > WIDTH_BITS) ? PULSE_BITS : WIDTH_BITS;
	localparam int CW   = WW + 2;
	localparam int CMPW = (PULSE_BITS > FRAME_BITS) ? PULSE_BITS : FRAME_BITS;
	localparam int PW   = ((FRAME_BITS > PERIOD_BITS) ? FRAME_BITS : PERIOD_BITS) + 1;
	localparam int PMAX_INT = (1 << PULSE_BITS) - 1;
	localparam logic [WW-1:0] PULSE_MAX = WW'(PMAX_INT);
	localparam logic [PULSE_BITS-1:0] POS_RESET =
		(CENTER_RESET > PMAX_INT) ? PULSE_BITS'(PMAX_INT) : PULSE_BITS'(CENTER_RESET);

	logic [PULSE_BITS-1:0] pan_pos_q, tilt_pos_q;
	logic [PULSE_BITS-1:0] pan_lat_q, tilt_lat_q;
	logic [FRAME_BITS-1:0] frame_cnt_q;
	logic [1:0]            held_q;
	logic                  rsp_valid_q;
	rsp_t                  rsp_q;

	logic [PULSE_BITS-1:0] pan_pos_n, tilt_pos_n;
	logic [PULSE_BITS-1:0] pan_lat_n, tilt_lat_n;
	logic [FRAME_BITS-1:0] frame_cnt_n;
	logic [1:0]            held_n;
	logic                  start;
	logic [FRAME_BITS:0]   cnt_inc;
	logic                  wrap;

	function automatic logic [PULSE_BITS-1:0] sat_width(input logic [WIDTH_BITS-1:0] v);
		logic [WW-1:0] ext;
		ext = WW'(v);
		if (ext > PULSE_MAX) begin
			return '1;
		end
		return PULSE_BITS'(ext);
	endfunction

	function automatic logic [WIDTH_BITS-1:0] to_field(input logic [PULSE_BITS-1:0] p);
		logic [WW-1:0] ext;
		ext = WW'(p);
		return ext[WIDTH_BITS-1:0];
	endfunction

	// Step by step_size, then clamp: minimum first, maximum second
	function automatic logic [PULSE_BITS-1:0] move_one(
		input logic [PULSE_BITS-1:0] pos,
		input logic [1:0]            dir,
		input logic [WIDTH_BITS-1:0] lo,
		input logic [WIDTH_BITS-1:0] hi,
		input logic [STEP_BITS-1:0]  step
	);
		logic signed [CW-1:0] pos_x, step_x, lo_x, hi_x, v;
		pos_x  = $signed(CW'(pos));
		step_x = $signed(CW'(step));
		lo_x   = $signed(CW'(lo));
		hi_x   = $signed(CW'(hi));
		v      = (dir == DIR_DEC) ? (pos_x - step_x) : (pos_x + step_x);
		if (dir != DIR_DEC && dir != DIR_INC) begin
			return pos;
		end else if (v < lo_x) begin
			return sat_width(lo);
		end else if (v > hi_x) begin
			return sat_width(hi);
		end
		return sat_width(v[WIDTH_BITS-1:0]);
	endfunction

	assign op_pop = op_valid && (!rsp_valid_q || rsp_ready);

	always_comb begin
		pan_pos_n   = pan_pos_q;
		tilt_pos_n  = tilt_pos_q;
		pan_lat_n   = pan_lat_q;
		tilt_lat_n  = tilt_lat_q;
		frame_cnt_n = frame_cnt_q;
		held_n      = held_q;
		start       = 1'b0;
		cnt_inc     = {1'b0, frame_cnt_q} + (FRAME_BITS + 1)'(1);
		wrap        = (PW'(cnt_inc) >= PW'(cfg.frame_period)) || cnt_inc[FRAME_BITS];
		case (op.op)
			OP_TICK: begin
				if (frame_cnt_q == '0) begin
					start      = 1'b1;
					pan_lat_n  = pan_pos_q;
					tilt_lat_n = tilt_pos_q;
				end
				held_n[0]   = CMPW'(frame_cnt_q) < CMPW'(pan_lat_n);
				held_n[1]   = CMPW'(frame_cnt_q) < CMPW'(tilt_lat_n);
				frame_cnt_n = wrap ? '0 : cnt_inc[FRAME_BITS-1:0];
			end
			OP_CENTER: begin
				pan_pos_n  = sat_width(cfg.pan_center);
				tilt_pos_n = sat_width(cfg.tilt_center);
			end
			OP_MOVE: begin
				pan_pos_n  = move_one(pan_pos_q, op.pan_dir, cfg.pan_minimum,
					cfg.pan_maximum, cfg.step_size);
				tilt_pos_n = move_one(tilt_pos_q, op.tilt_dir, cfg.tilt_minimum,
					cfg.tilt_maximum, cfg.step_size);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pan_pos_q   <= POS_RESET;
			tilt_pos_q  <= POS_RESET;
			pan_lat_q   <= '0;
			tilt_lat_q  <= '0;
			frame_cnt_q <= '0;
			held_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (op_pop) begin
				pan_pos_q   <= pan_pos_n;
				tilt_pos_q  <= tilt_pos_n;
				pan_lat_q   <= pan_lat_n;
				tilt_lat_q  <= tilt_lat_n;
				frame_cnt_q <= frame_cnt_n;
				held_q      <= held_n;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (op_pop) begin
			rsp_q.pan_level   <= held_n[0];
			rsp_q.tilt_level  <= held_n[1];
			rsp_q.frame_start <= start;
			rsp_q.pan_width   <= to_field(pan_pos_n);
			rsp_q.tilt_width  <= to_field(tilt_pos_n);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	a_latch_at_zero: assert property (@(posedge clk) disable iff (!arst_n)
		op_pop && op.op == OP_TICK && frame_cnt_q == '0
		|=> pan_lat_q == $past(pan_pos_q) && tilt_lat_q == $past(tilt_pos_q))
		else $error("widths not latched at frame start");

	a_cmd_holds_counter: assert property (@(posedge clk) disable iff (!arst_n)
		op_pop && op.op != OP_TICK
		|=> frame_cnt_q == $past(frame_cnt_q) && held_q == $past(held_q))
		else $error("command moved the frame counter or levels");

	a_start_levels: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.frame_start
		|-> rsp_q.pan_level == (pan_lat_q != '0) && rsp_q.tilt_level == (tilt_lat_q != '0))
		else $error("frame start levels disagree with latched widths");
`endif

endmodule

// ===== hw/rtl/pan_tilt_servo_stepper_pwm.sv =====
// Top level of the two-channel pan/tilt servo pulse generator.
//
// Usage:
//   cmd channel (cmd_valid/cmd_ready/cmd): one transaction per item. mode 0 is a
//   one-microsecond tick, 1 centers both servos, 2 is stop (no change), 3 moves
//   each channel by step_size in the direction given (out-of-range code = hold).
//   rsp channel (rsp_valid/rsp_ready/rsp): exactly one transaction per command,
//   in order, carrying the pin levels, the frame-start flag and both widths.
//   cfg channel (cfg_valid/cfg_ready/cfg_addr/cfg_wdata): always ready; writes
//   the register at cfg_addr. Write only while no command is in flight.
// Timing:
//   A command reaches rsp_valid through these registers in order: the front
//   decode register loads at the accepting edge, then the queue, then the
//   response register. Throughput is one command per cycle while rsp_ready
//   stays high; the back part closes add, clamp and compare combinationally.
// Reset (arst_n low, asynchronous): widths to 1500, latched widths and frame
//   counter to zero, levels low, registers to their defaults, channels empty.
// Stall: when rsp_ready is low the response holds, the queue absorbs two more
//   operations plus one in the front register, then cmd_ready drops.
module pan_tilt_servo_stepper_pwm #(
	parameter int PULSE_BITS = 12,
	parameter int FRAME_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cmd_valid,
	output logic                               cmd_ready,
	input  ptsp_pkg::cmd_t                     cmd,
	output logic                               rsp_valid,
	input  logic                               rsp_ready,
	output ptsp_pkg::rsp_t                     rsp,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [ptsp_pkg::CFG_ADDR_W-1:0]    cfg_addr,
	input  logic [ptsp_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
	import ptsp_pkg::*;

	cfg_t cfg_q;
	op_t  front_op;
	logic front_valid;
	logic queue_ready;
	op_t  queue_op;
	logic queue_valid;
	logic back_pop;

	// Register file; writes never stall
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_size    <= STEP_BITS'(25);
			cfg_q.pan_minimum  <= WIDTH_BITS'(800);
			cfg_q.pan_center   <= WIDTH_BITS'(1500);
			cfg_q.pan_maximum  <= WIDTH_BITS'(2200);
			cfg_q.tilt_minimum <= WIDTH_BITS'(1200);
			cfg_q.tilt_center  <= WIDTH_BITS'(1500);
			cfg_q.tilt_maximum <= WIDTH_BITS'(2000);
			cfg_q.frame_period <= PERIOD_BITS'(20000);
		end else if (cfg_valid) begin
			case (cfg_addr)
				REG_STEP_SIZE:    cfg_q.step_size    <= cfg_wdata[STEP_BITS-1:0];
				REG_PAN_MINIMUM:  cfg_q.pan_minimum  <= cfg_wdata[WIDTH_BITS-1:0];
				REG_PAN_CENTER:   cfg_q.pan_center   <= cfg_wdata[WIDTH_BITS-1:0];
				REG_PAN_MAXIMUM:  cfg_q.pan_maximum  <= cfg_wdata[WIDTH_BITS-1:0];
				REG_TILT_MINIMUM: cfg_q.tilt_minimum <= cfg_wdata[WIDTH_BITS-1:0];
				REG_TILT_CENTER:  cfg_q.tilt_center  <= cfg_wdata[WIDTH_BITS-1:0];
				REG_TILT_MAXIMUM: cfg_q.tilt_maximum <= cfg_wdata[WIDTH_BITS-1:0];
				REG_FRAME_PERIOD: cfg_q.frame_period <= cfg_wdata[PERIOD_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	// Front: accept and decode
	ptsp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.op_valid  (front_valid),
		.op_ready  (queue_ready),
		.op        (front_op)
	);

	// Decouples the decode stage from response back-pressure
	ptsp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (queue_ready),
		.push_op    (front_op),
		.pop_valid  (queue_valid),
		.pop        (back_pop),
		.pop_op     (queue_op)
	);

	// Back: position update, frame counter, levels, response register
	ptsp_back #(
		.PULSE_BITS (PULSE_BITS),
		.FRAME_BITS (FRAME_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.op_valid  (queue_valid),
		.op_pop    (back_pop),
		.op        (queue_op),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule
